FILE: src/krfd_pkg.sv
// ----------------------------------------------------------------------------
// krfd_pkg
// Shared types, register codes and helpers for the key region fill detector.
// ----------------------------------------------------------------------------
package krfd_pkg;

    localparam int BOUND_W    = 10;
    localparam int NUM_BOUNDS = 15;
    localparam int BOUNDS_W   = NUM_BOUNDS * BOUND_W;
    localparam int REG_W      = 50;
    localparam int CNT_W      = 19;
    localparam int MASK_W     = 14;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [2:0] REG_TOP_ROW       = 3'd0;
    localparam logic [2:0] REG_BOTTOM_ROW    = 3'd1;
    localparam logic [2:0] REG_GRAY_THRESH   = 3'd2;
    localparam logic [2:0] REG_FILL_TENTHS   = 3'd3;
    localparam logic [2:0] REG_BOUNDS_FIRST  = 3'd4;
    localparam logic [2:0] REG_BOUNDS_MIDDLE = 3'd5;
    localparam logic [2:0] REG_BOUNDS_LAST   = 3'd6;

    // fixed point luma weights, scaled by 2^14
    localparam logic [21:0] GRAY_W_B   = 22'd1868;
    localparam logic [21:0] GRAY_W_G   = 22'd9617;
    localparam logic [21:0] GRAY_W_R   = 22'd4899;
    localparam logic [21:0] GRAY_ROUND = 22'd8192;

    typedef struct packed {
        logic [8:0]          top_row;
        logic [8:0]          bottom_row;
        logic [7:0]          gray_threshold;
        logic [3:0]          fill_tenths;
        logic [BOUNDS_W-1:0] bounds;
    } cfg_t;

    // column boundary k, zero past the last stored one
    function automatic logic [BOUND_W-1:0] bound_at(input logic [BOUNDS_W-1:0] bounds,
                                                    input logic [5:0] k);
        logic [BOUND_W-1:0] b;
        b = '0;
        if (k < 6'(NUM_BOUNDS)) begin
            b = bounds[k*BOUND_W +: BOUND_W];
        end
        return b;
    endfunction

    function automatic logic [9:0] clip10(input logic [9:0] v, input logic [9:0] lim);
        return (v < lim) ? v : lim;
    endfunction

endpackage

FILE: src/krfd_front.sv
// ----------------------------------------------------------------------------
// krfd_front
// Takes pixels, converts to gray and classifies each into a per-key hit mask.
// ----------------------------------------------------------------------------
module krfd_front
    import krfd_pkg::*;
#(
    parameter int NUM_KEYS     = 14,
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [9:0]          pixel_x,
    input  logic [8:0]          pixel_y,
    input  logic [7:0]          blue,
    input  logic [7:0]          green,
    input  logic [7:0]          red,
    input  logic                frame_end,
    output logic                push,
    input  logic                q_full,
    output logic [NUM_KEYS:0]   push_data   // hit mask, frame end on top
);

    logic       vld_reg, vld_next;
    logic [9:0] x_reg, x_next;
    logic [8:0] y_reg, y_next;
    logic [7:0] gray_reg, gray_next;
    logic       last_reg, last_next;
    logic [21:0] gray_sum;
    logic        lit, in_frame, in_band;
    logic [NUM_KEYS-1:0] hits;

    assign gray_sum = 22'(blue) * GRAY_W_B + 22'(green) * GRAY_W_G
                    + 22'(red) * GRAY_W_R + GRAY_ROUND;

    assign in_ready = !vld_reg || !q_full;

    always_comb begin
        vld_next  = vld_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        gray_next = gray_reg;
        last_next = last_reg;
        if (in_ready) begin
            vld_next  = in_valid;
            x_next    = pixel_x;
            y_next    = pixel_y;
            gray_next = gray_sum[21:14];
            last_next = frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        gray_reg <= gray_next;
        last_reg <= last_next;
    end

    assign lit      = gray_reg > cfg.gray_threshold;
    assign in_frame = (x_reg < 10'(FRAME_WIDTH)) && ({1'b0, y_reg} < 10'(FRAME_HEIGHT));
    assign in_band  = (y_reg >= cfg.top_row) && (y_reg < cfg.bottom_row);

    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            hits[i] = lit && in_frame && in_band
                   && (x_reg >= bound_at(cfg.bounds, 6'(i)))
                   && (x_reg <  bound_at(cfg.bounds, 6'(i + 1)));
        end
    end

    assign push      = vld_reg && !q_full;
    assign push_data = {last_reg, hits};

endmodule

FILE: src/krfd_queue.sv
// ----------------------------------------------------------------------------
// krfd_queue
// Short first-in first-out queue between the classifier and the counters.
// ----------------------------------------------------------------------------
module krfd_queue
    import krfd_pkg::*;
#(
    parameter int WIDTH = 15
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/krfd_back.sv
// ----------------------------------------------------------------------------
// krfd_back
// Per-key lit counters, end of frame fill evaluation and the result register.
// ----------------------------------------------------------------------------
module krfd_back
    import krfd_pkg::*;
#(
    parameter int NUM_KEYS     = 14,
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  logic [NUM_KEYS:0] pop_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MASK_W-1:0] keys_held,
    output logic [MASK_W-1:0] keys_struck
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int IDX_W = $clog2(NUM_KEYS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_COUNT = 3'b001,
        ST_EVAL  = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg [NUM_KEYS];
    logic [CNT_W-1:0]    cnt_next [NUM_KEYS];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [19:0]         area_reg, area_next;
    logic [NUM_KEYS-1:0] acc_reg, acc_next;
    logic [MASK_W-1:0]   held_flags_reg, held_flags_next;
    logic                out_vld_reg, out_vld_next;
    logic [MASK_W-1:0]   held_reg, held_next;
    logic [MASK_W-1:0]   struck_reg, struck_next;

    logic [9:0]          hgt, wid, lft, rgt, top_c, bot_c;
    logic [CNT_W-1:0]    cnt_sel;
    logic [23:0]         lhs, rhs;
    logic                key_held;
    logic [31:0]         acc_wide;
    logic [MASK_W-1:0]   held_mask;

    // height of the band inside the frame
    assign top_c = clip10({1'b0, cfg.top_row}, 10'(FRAME_HEIGHT));
    assign bot_c = clip10({1'b0, cfg.bottom_row}, 10'(FRAME_HEIGHT));
    assign hgt   = (bot_c > top_c) ? bot_c - top_c : 10'd0;

    assign lft = clip10(bound_at(cfg.bounds, 6'(idx_reg)), 10'(FRAME_WIDTH));
    assign rgt = clip10(bound_at(cfg.bounds, 6'(idx_reg) + 6'd1), 10'(FRAME_WIDTH));
    assign wid = (rgt > lft) ? rgt - lft : 10'd0;

    // count*10 > fill*area
    assign cnt_sel  = cnt_reg[cmp_idx_reg];
    assign lhs      = 24'({cnt_sel, 3'b000}) + 24'({cnt_sel, 1'b0});
    assign rhs      = 24'(cfg.fill_tenths) * 24'(area_reg);
    assign key_held = (area_reg != '0) && (lhs > rhs);

    assign acc_wide  = 32'(acc_next);
    assign held_mask = acc_wide[MASK_W-1:0];

    assign pop = (state_reg == ST_COUNT) && !q_empty;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = 1'b0;
        area_next       = area_reg;
        acc_next        = acc_reg;
        held_flags_next = held_flags_reg;
        out_vld_next    = out_vld_reg && !out_ready;
        held_next       = held_reg;
        struck_next     = struck_reg;

        if (cmp_vld_reg && key_held) begin
            acc_next[cmp_idx_reg] = 1'b1;
        end

        case (state_reg)
            ST_COUNT: begin
                if (pop) begin
                    for (int i = 0; i < NUM_KEYS; i++) begin
                        if (pop_data[i] && cnt_reg[i] != CNT_MAX) begin
                            cnt_next[i] = cnt_reg[i] + 1'b1;
                        end
                    end
                    if (pop_data[NUM_KEYS]) begin
                        state_next = ST_EVAL;
                        idx_next   = '0;
                        acc_next   = '0;
                    end
                end
            end
            ST_EVAL: begin
                // area of one key per cycle, compared the cycle after
                if (idx_reg < IDX_W'(NUM_KEYS)) begin
                    area_next    = 20'(wid) * 20'(hgt);
                    cmp_idx_next = idx_reg[KEY_W-1:0];
                    cmp_vld_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_vld_reg || out_ready) begin
                    out_vld_next    = 1'b1;
                    held_next       = held_mask;
                    struck_next     = held_mask & ~held_flags_reg;
                    held_flags_next = held_mask;
                    for (int i = 0; i < NUM_KEYS; i++) begin
                        cnt_next[i] = '0;
                    end
                    state_next = ST_COUNT;
                end
            end
            default: begin
                state_next = ST_COUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_COUNT;
            idx_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            acc_reg        <= '0;
            held_flags_reg <= '0;
            out_vld_reg    <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            acc_reg        <= acc_next;
            held_flags_reg <= held_flags_next;
            out_vld_reg    <= out_vld_next;
            cnt_reg        <= cnt_next;
        end
        cmp_idx_reg <= cmp_idx_next;
        area_reg    <= area_next;
        held_reg    <= held_next;
        struck_reg  <= struck_next;
    end

    assign out_valid   = out_vld_reg;
    assign keys_held   = held_reg;
    assign keys_struck = struck_reg;

endmodule

FILE: src/key_region_fill_detector.sv
// ----------------------------------------------------------------------------
// key_region_fill_detector
// Counts lit pixels per key region and reports held and newly struck keys.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream, one per request, in raster order; tlast marks
// the last pixel of a frame. A classifier stage turns each pixel into gray and
// a per-key hit mask, which passes through a four-entry queue to the counters.
// Pixels are taken at one per cycle while s_tready is high. Only the frame
// end request gives a result: after its pixel is counted the keys are judged
// one per cycle through a shared area multiplier and the result is loaded into
// the output register for the m_ stream; meanwhile the queue absorbs the
// pixels that follow until it fills, then s_tready drops.
// Results sit in an output register; when the receiver stalls, the next frame
// end waits in the done state and the queue backs up to the input.
// Configuration writes on cfg_ are always taken and must come while the block
// is idle. After reset all counters and the held mask are zero and the
// registers hold their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_region_fill_detector
    import krfd_pkg::*;
#(
    parameter int NUM_KEYS     = 14,
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // pixel_x, pixel_y, blue, green, red, zero fill
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // keys_held, keys_struck, zero fill
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [REG_W-1:0]  cfg_data
);

    cfg_t              cfg_reg, cfg_next;
    logic              push, pop, q_full, q_empty;
    logic [NUM_KEYS:0] push_data, pop_data;
    logic [MASK_W-1:0] keys_held, keys_struck;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_TOP_ROW:       cfg_next.top_row = cfg_data[8:0];
                REG_BOTTOM_ROW:    cfg_next.bottom_row = cfg_data[8:0];
                REG_GRAY_THRESH:   cfg_next.gray_threshold = cfg_data[7:0];
                REG_FILL_TENTHS:   cfg_next.fill_tenths = cfg_data[3:0];
                REG_BOUNDS_FIRST:  cfg_next.bounds[REG_W-1:0] = cfg_data;
                REG_BOUNDS_MIDDLE: cfg_next.bounds[2*REG_W-1:REG_W] = cfg_data;
                REG_BOUNDS_LAST:   cfg_next.bounds[3*REG_W-1:2*REG_W] = cfg_data;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.top_row        <= 9'd0;
            cfg_reg.bottom_row     <= 9'd480;
            cfg_reg.gray_threshold <= 8'd100;
            cfg_reg.fill_tenths    <= 4'd7;
            cfg_reg.bounds         <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    krfd_front #(
        .NUM_KEYS     (NUM_KEYS),
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pixel_x   (s_tdata[9:0]),
        .pixel_y   (s_tdata[18:10]),
        .blue      (s_tdata[26:19]),
        .green     (s_tdata[34:27]),
        .red       (s_tdata[42:35]),
        .frame_end (s_tlast),
        .push      (push),
        .q_full    (q_full),
        .push_data (push_data)
    );

    krfd_queue #(
        .WIDTH (NUM_KEYS + 1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    krfd_back #(
        .NUM_KEYS     (NUM_KEYS),
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .keys_held   (keys_held),
        .keys_struck (keys_struck)
    );

    assign m_tdata = {4'b0000, keys_struck, keys_held};

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_region_fill_detector. Pixels are streamed in
// with random gaps, results are drained with random stalls, and every result
// is compared against a behavioral model of the per-key lit counters and the
// held / struck masks kept inside this bench.
// ----------------------------------------------------------------------------
module tb;
    import krfd_pkg::*;

    localparam int N_KEYS        = 14;
    localparam int FRAME_W       = 640;
    localparam int FRAME_H       = 480;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 520;

    typedef struct packed {
        logic [MASK_W-1:0] held;
        logic [MASK_W-1:0] struck;
    } key_masks_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [47:0]      s_tdata;   // pixel_x, pixel_y, blue, green, red, zero fill
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [31:0]      m_tdata;   // keys_held, keys_struck, zero fill
    logic             cfg_valid;
    logic             cfg_ready;
    logic [2:0]       cfg_index;
    logic [REG_W-1:0] cfg_data;

    // model copy of the registers and counters
    logic [8:0]          mdl_top;
    logic [8:0]          mdl_bottom;
    logic [7:0]          mdl_thresh;
    logic [3:0]          mdl_fill;
    logic [REG_W-1:0]    mdl_bounds [3];
    logic [CNT_W-1:0]    lit_count [N_KEYS];
    logic [MASK_W-1:0]   held_prev;
    key_masks_t          pending_masks [$];

    logic [BOUNDS_W-1:0] new_bounds;
    int                  pixels_sent;
    int                  fail_count;
    int                  cycle_count;
    bit                  src_idle;
    bit                  sink_idle;

    key_region_fill_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic void init_model();
        mdl_top       = 9'd0;
        mdl_bottom    = 9'd480;
        mdl_thresh    = 8'd100;
        mdl_fill      = 4'd7;
        mdl_bounds[0] = '0;
        mdl_bounds[1] = '0;
        mdl_bounds[2] = '0;
        for (int k = 0; k < N_KEYS; k++) lit_count[k] = '0;
        held_prev = '0;
    endfunction

    // column boundary k; past the last stored boundary it reads as zero
    function automatic int key_bound(input int k);
        if (k > 14) return 0;
        return int'((mdl_bounds[k / 5] >> ((k % 5) * 10)) & 50'h3FF);
    endfunction

    function automatic int clip_to(input int v, input int lim);
        return (v < lim) ? v : lim;
    endfunction

    function automatic void track_pixel(input int x, input int y, input int b,
                                        input int g, input int r, input bit last);
        int                gray;
        int                lo;
        int                hi;
        int                hgt;
        longint            area;
        logic [MASK_W-1:0] held;
        key_masks_t        masks;
        gray = (1868 * b + 9617 * g + 4899 * r + 8192) >> 14;
        if (gray > int'(mdl_thresh) && x < FRAME_W && y < FRAME_H &&
            y >= int'(mdl_top) && y < int'(mdl_bottom)) begin
            // overlapping regions all take the pixel
            for (int k = 0; k < N_KEYS; k++) begin
                if (x >= key_bound(k) && x < key_bound(k + 1) && lit_count[k] != '1) begin
                    lit_count[k]++;
                end
            end
        end
        if (last) begin
            held = '0;
            lo   = clip_to(int'(mdl_top), FRAME_H);
            hi   = clip_to(int'(mdl_bottom), FRAME_H);
            hgt  = (hi > lo) ? hi - lo : 0;
            for (int k = 0; k < N_KEYS; k++) begin
                lo   = clip_to(key_bound(k), FRAME_W);
                hi   = clip_to(key_bound(k + 1), FRAME_W);
                area = (hi > lo) ? longint'(hi - lo) * hgt : 0;
                if (area != 0 && longint'(lit_count[k]) * 10 > longint'(mdl_fill) * area) begin
                    held[k] = 1'b1;
                end
                lit_count[k] = '0;
            end
            masks.held   = held;
            masks.struck = held & ~held_prev;
            held_prev    = held;
            pending_masks.push_back(masks);
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_pixel(input int x, input int y, input int b, input int g,
                              input int r, input bit last);
        int gap;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, 8'(r), 8'(g), 8'(b), 9'(y), 10'(x)};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_pixel(x, y, b, g, r, last);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [REG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TOP_ROW:       mdl_top       = val[8:0];
            REG_BOTTOM_ROW:    mdl_bottom    = val[8:0];
            REG_GRAY_THRESH:   mdl_thresh    = val[7:0];
            REG_FILL_TENTHS:   mdl_fill      = val[3:0];
            REG_BOUNDS_FIRST:  mdl_bounds[0] = val;
            REG_BOUNDS_MIDDLE: mdl_bounds[1] = val;
            REG_BOUNDS_LAST:   mdl_bounds[2] = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_band(input int top, input int bottom, input int thresh,
                              input int fill);
        write_reg(REG_TOP_ROW, REG_W'(top));
        write_reg(REG_BOTTOM_ROW, REG_W'(bottom));
        write_reg(REG_GRAY_THRESH, REG_W'(thresh));
        write_reg(REG_FILL_TENTHS, REG_W'(fill));
    endtask

    task automatic write_bounds();
        write_reg(REG_BOUNDS_FIRST, new_bounds[49:0]);
        write_reg(REG_BOUNDS_MIDDLE, new_bounds[99:50]);
        write_reg(REG_BOUNDS_LAST, new_bounds[149:100]);
    endtask

    // wait until every frame result is back and the block has gone quiet
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_masks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin : sink_stalls
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = sink_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : check_masks
        key_masks_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_masks.size() == 0) begin
                if (fail_count < 10) $display("unexpected result %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_masks.pop_front();
                if (m_tdata[13:0] !== want.held || m_tdata[27:14] !== want.struck) begin
                    if (fail_count < 10) begin
                        $display("mask mismatch: held exp %h got %h, struck exp %h got %h",
                                 want.held, m_tdata[13:0], want.struck, m_tdata[27:14]);
                    end
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset bounds are all zero, so every region is empty
    task automatic test_reset_values();
        send_pixel(0, 0, 255, 255, 255, 1'b0);
        send_pixel(320, 240, 255, 255, 255, 1'b0);
        send_pixel(639, 479, 255, 255, 255, 1'b1);
        drain_results();
    endtask

    task automatic test_key_regions();
        // empty, overlapping and off-frame regions side by side
        int dir_b [15] = '{0, 1, 3, 2, 4, 630, 1023, 1023, 0, 5, 9, 9, 640, 600, 1023};
        for (int k = 0; k < 15; k++) new_bounds[k * 10 +: 10] = 10'(dir_b[k]);
        write_bounds();
        write_band(100, 102, 0, 5);
        send_pixel(0, 100, 255, 255, 255, 1'b0);
        send_pixel(0, 101, 255, 255, 255, 1'b0);
        send_pixel(2, 100, 255, 0, 0, 1'b0);
        send_pixel(1, 100, 0, 0, 0, 1'b0);
        send_pixel(639, 479, 255, 255, 255, 1'b0);
        send_pixel(1023, 100, 255, 255, 255, 1'b0);
        send_pixel(639, 101, 0, 255, 0, 1'b0);
        send_pixel(0, 99, 255, 255, 255, 1'b0);
        send_pixel(0, 102, 255, 255, 255, 1'b0);
        send_pixel(1, 101, 0, 0, 255, 1'b1);
        // held key falls back, struck follows the rising edge only
        send_pixel(0, 100, 255, 255, 255, 1'b1);
        drain_results();
        // fill above ten, duplicate pixels push the count past the area
        write_reg(REG_FILL_TENTHS, REG_W'(15));
        repeat (4) send_pixel(0, 100, 255, 255, 255, 1'b0);
        send_pixel(0, 101, 255, 255, 255, 1'b1);
        drain_results();
        // nothing can exceed the top threshold
        write_band(100, 102, 255, 0);
        send_pixel(0, 100, 255, 255, 255, 1'b1);
        drain_results();
        // band runs past the bottom of the frame
        write_band(470, 511, 0, 0);
        send_pixel(5, 511, 255, 255, 255, 1'b0);
        send_pixel(5, 479, 255, 255, 255, 1'b1);
        drain_results();
        // empty band
        write_band(200, 200, 0, 0);
        send_pixel(0, 200, 255, 255, 255, 1'b1);
        drain_results();
    endtask

    task automatic randomize_config();
        int top;
        int bottom;
        int v;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            top    = $urandom_range(0, 479);
            bottom = top + $urandom_range(0, 3);
        end else if (pick == 7) begin
            top    = 0;
            bottom = 511;
        end else if (pick == 8) begin
            top    = 511;
            bottom = 0;
        end else begin
            top    = $urandom_range(0, 511);
            bottom = $urandom_range(0, 511);
        end
        pick = $urandom_range(0, 9);
        v    = $urandom_range(0, 639);
        for (int k = 0; k < 15; k++) begin
            if (pick < 7) begin
                new_bounds[k * 10 +: 10] = 10'(v);
                v += $urandom_range(0, 3);
            end else if (pick == 7) begin
                new_bounds[k * 10 +: 10] = 10'($urandom_range(0, 1023));
            end else if (pick == 8) begin
                new_bounds[k * 10 +: 10] = '1;
            end else begin
                new_bounds[k * 10 +: 10] = '0;
            end
        end
        write_bounds();
        pick = $urandom_range(0, 9);
        v    = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 180);
        write_band(top, bottom, v, $urandom_range(0, 15));
    endtask

    task automatic send_random_pixel(input bit last);
        int k;
        int lo;
        int hi;
        int x;
        int y;
        if ($urandom_range(0, 9) < 8) begin
            // aim at one key region inside the band
            k  = $urandom_range(0, N_KEYS - 1);
            lo = key_bound(k);
            hi = key_bound(k + 1);
            x  = (hi > lo) ? $urandom_range(lo, hi - 1) : lo;
            lo = int'(mdl_top);
            hi = int'(mdl_bottom);
            y  = (hi > lo) ? $urandom_range(lo, hi - 1) : lo;
        end else begin
            x = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 639);
            y = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 479);
        end
        send_pixel(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), last);
    endtask

    task automatic test_random_frames();
        int start;
        int frames;
        int n;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            drain_results();
            randomize_config();
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            frames    = $urandom_range(1, 4);
            repeat (frames) begin
                n = $urandom_range(0, 19);
                repeat (n) send_random_pixel(1'b0);
                send_random_pixel(1'b1);
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_TOP_ROW;
        cfg_data    = '0;
        src_idle    = 1'b0;
        sink_idle   = 1'b0;
        pixels_sent = 0;
        fail_count  = 0;
        cycle_count = 0;
        init_model();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        test_key_regions();
        test_random_frames();
        drain_results();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
